[hdl/alte_pkg.sv]
// Shared types for the array list engine: action and status codes, the
// sequencer state enum and the result record. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package alte_pkg;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_LOCATE = 2'd1,
        ACT_READ   = 2'd2,
        ACT_DELETE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_FULL      = 2'd1,
        STS_NOT_FOUND = 2'd2,
        STS_BAD_INDEX = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_status     status;
        logic [6:0]  found_position;
        logic [31:0] read_value;
        logic [7:0]  count;
    } t_result;

endpackage

`default_nettype wire

[hdl/array_list_table_engine.sv]
// Top level of the array list engine: sequencer, entry store and output
// register. Depends on alte_pkg, alte_seq and alte_mem.
//
// A packed list of signed 32-bit values in a store of DEPTH entries with a
// count of entries in use. Each item carries an action: append stores the
// value at the end (status full when count equals DEPTH), locate returns the
// lowest position holding the value, read returns the entry at position
// (status invalid index when position is not below count), delete removes the
// first match and slides every later entry down one place. Every result
// carries the count after the action; found_position and read_value are zero
// unless the action succeeded. Values match bit for bit. One item is worked
// at a time. The store has one read port, so the search sweeps it one entry
// per cycle and the shift picks up at the match and moves one entry per
// cycle, so search and shift together cover the list once. The next item is
// taken once the sequencer is back to idle; the output register holds a
// finished result while the next item is at work. No clearing pass after
// reset: the data of entries beyond count is never used.
`timescale 1ns / 1ps
`default_nettype none

module array_list_table_engine #(
    parameter int unsigned DEPTH = 128
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [1:0]         i_action,
    input  wire logic signed [31:0] i_value,
    input  wire logic [6:0]         i_position,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [1:0]              o_status,
    output logic [6:0]              o_found_position,
    output logic signed [31:0]      o_read_value,
    output logic [7:0]              o_count
);

    localparam int unsigned AW = $clog2(DEPTH);

    // sequencer to store
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_data;

    // sequencer to output register
    logic              res_valid;
    logic              res_ready;
    alte_pkg::t_result res;

    logic              r_out_valid;
    alte_pkg::t_result r_out;

    alte_seq #(
        .DEPTH(DEPTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_action    (i_action),
        .i_value     (i_value),
        .i_position  (i_position),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    alte_mem #(
        .DEPTH(DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // output register: takes a result when empty or being drained
    assign res_ready = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out.status;
    assign o_found_position = r_out.found_position;
    assign o_read_value     = r_out.read_value;
    assign o_count          = r_out.count;

endmodule

`default_nettype wire

[hdl/alte_mem.sv]
// Entry store of the array list engine: one write port, one read port,
// registered read data. Standalone, no package use.
`timescale 1ns / 1ps
`default_nettype none

module alte_mem #(
    parameter int unsigned DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [31:0]              i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [31:0]              o_rd_data
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[hdl/alte_seq.sv]
// Sequencer of the array list engine: entry count, search and shift passes
// over the entry store. Uses alte_pkg types; drives the ports of alte_mem.
`timescale 1ns / 1ps
`default_nettype none

module alte_seq #(
    parameter int unsigned DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [1:0]               i_action,
    input  wire logic [31:0]              i_value,
    input  wire logic [6:0]               i_position,
    output logic                          o_res_valid,
    input  wire logic                     i_res_ready,
    output alte_pkg::t_result             o_res,
    output logic                          o_wr_en,
    output logic [$clog2(DEPTH)-1:0]      o_wr_addr,
    output logic [31:0]                   o_wr_data,
    output logic [$clog2(DEPTH)-1:0]      o_rd_addr,
    input  wire logic [31:0]              i_rd_data
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned PW = (CW > 7) ? CW : 7;

    alte_pkg::t_state  r_state,  n_state;
    alte_pkg::t_action r_action, n_action;
    alte_pkg::t_status r_status, n_status;
    logic [31:0]       r_value,  n_value;
    logic [CW-1:0]     r_count,  n_count;
    logic [AW-1:0]     r_idx,    n_idx;
    logic [AW-1:0]     r_found,  n_found;
    logic [31:0]       r_rdata,  n_rdata;

    logic [CW-1:0] idx_ext;
    logic [CW-1:0] idx_next;
    logic          pos_ok;
    logic          list_full;

    assign idx_ext   = CW'(r_idx);
    assign idx_next  = idx_ext + CW'(1);
    assign pos_ok    = PW'(i_position) < PW'(r_count);
    assign list_full = (r_count == CW'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= alte_pkg::ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_status <= n_status;
        r_value  <= n_value;
        r_idx    <= n_idx;
        r_found  <= n_found;
        r_rdata  <= n_rdata;
    end

    always_comb begin
        n_state   = r_state;
        n_action  = r_action;
        n_status  = r_status;
        n_value   = r_value;
        n_count   = r_count;
        n_idx     = r_idx;
        n_found   = r_found;
        n_rdata   = r_rdata;
        o_wr_en   = 1'b0;
        o_wr_addr = AW'(r_count);
        o_wr_data = i_value;
        o_rd_addr = AW'(idx_next);
        o_ready   = 1'b0;

        case (r_state)
            alte_pkg::ST_IDLE: begin
                o_ready   = 1'b1;
                o_rd_addr = (alte_pkg::t_action'(i_action) == alte_pkg::ACT_READ) ?
                            AW'(i_position) : '0;
                if (i_valid) begin
                    n_action = alte_pkg::t_action'(i_action);
                    n_value  = i_value;
                    n_status = alte_pkg::STS_OK;
                    n_found  = '0;
                    n_rdata  = '0;
                    n_idx    = '0;
                    case (alte_pkg::t_action'(i_action))
                        alte_pkg::ACT_APPEND: begin
                            if (list_full) begin
                                n_status = alte_pkg::STS_FULL;
                            end else begin
                                o_wr_en = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                            n_state = alte_pkg::ST_DONE;
                        end
                        alte_pkg::ACT_READ: begin
                            if (pos_ok) begin
                                n_state = alte_pkg::ST_READ;
                            end else begin
                                n_status = alte_pkg::STS_BAD_INDEX;
                                n_state  = alte_pkg::ST_DONE;
                            end
                        end
                        alte_pkg::ACT_LOCATE, alte_pkg::ACT_DELETE: begin
                            if (r_count == '0) begin
                                n_status = alte_pkg::STS_NOT_FOUND;
                                n_state  = alte_pkg::ST_DONE;
                            end else begin
                                n_state = alte_pkg::ST_SCAN;
                            end
                        end
                        default: begin
                            n_state = alte_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            alte_pkg::ST_READ: begin
                n_rdata = i_rd_data;
                n_state = alte_pkg::ST_DONE;
            end
            alte_pkg::ST_SCAN: begin
                // read data belongs to r_idx; next address already on the port
                if (i_rd_data == r_value) begin
                    if (r_action == alte_pkg::ACT_LOCATE) begin
                        n_found = r_idx;
                        n_state = alte_pkg::ST_DONE;
                    end else begin
                        n_state = alte_pkg::ST_SHIFT;
                    end
                end else if (idx_next == r_count) begin
                    n_status = alte_pkg::STS_NOT_FOUND;
                    n_state  = alte_pkg::ST_DONE;
                end else begin
                    n_idx = AW'(idx_next);
                end
            end
            alte_pkg::ST_SHIFT: begin
                // read data is entry r_idx+1; move it to r_idx
                o_rd_addr = AW'(idx_ext + CW'(2));
                if (idx_next < r_count) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_idx;
                    o_wr_data = i_rd_data;
                    n_idx     = AW'(idx_next);
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = alte_pkg::ST_DONE;
                end
            end
            alte_pkg::ST_DONE: begin
                if (i_res_ready) begin
                    n_state = alte_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = alte_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_res_valid          = (r_state == alte_pkg::ST_DONE);
    assign o_res.status         = r_status;
    assign o_res.found_position = 7'(r_found);
    assign o_res.read_value     = r_rdata;
    assign o_res.count          = 8'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (r_state == alte_pkg::ST_IDLE || r_state == alte_pkg::ST_SHIFT))
        else $error("store written outside append or shift");

    a_shift_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wr_en && r_state == alte_pkg::ST_SHIFT) |-> (idx_next < r_count))
        else $error("shift writes past the list end");

    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_count != $past(r_count)) |->
        ($past(r_state) == alte_pkg::ST_IDLE || $past(r_state) == alte_pkg::ST_SHIFT))
        else $error("count changed outside append or delete");

endmodule

`default_nettype wire
